FILE: sv/des_pkg.sv
// DES package: permutation helpers, S-boxes and key schedule tables.
package des_pkg;

    localparam int NumRounds = 16;

    typedef logic [47:0] subkey_t;
    typedef subkey_t subkeys_t [NumRounds];

    typedef struct packed {
        logic        valid;
        logic        decrypt;
        logic [31:0] left;
        logic [31:0] right;
    } stage_t;

    localparam logic [4:0] RotTab [NumRounds] =
        '{5'd1, 5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2,
          5'd1, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd2, 5'd1};

    localparam logic [3:0] SboxTab [8][64] = '{
        '{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
          4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
          4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
          4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
        '{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
          4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
          4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
          4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
        '{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
          4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
          4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
          4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
        '{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
          4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
          4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
          4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
        '{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
          4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
          4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
          4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
        '{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
          4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
          4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
          4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
        '{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
          4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
          4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
          4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
        '{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
          4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
          4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
          4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd5,4'd6,4'd11,4'd3}
    };

    localparam logic [6:0] IpTab [64] = '{
        7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,7'd10,7'd2,7'd60,7'd52,7'd44,7'd36,7'd28,7'd20,
        7'd12,7'd4,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,7'd14,7'd6,7'd64,7'd56,7'd48,7'd40,
        7'd32,7'd24,7'd16,7'd8,7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd59,7'd51,
        7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7};
    localparam logic [6:0] FpTab [64] = '{
        7'd40,7'd8,7'd48,7'd16,7'd56,7'd24,7'd64,7'd32,7'd39,7'd7,7'd47,7'd15,7'd55,7'd23,
        7'd63,7'd31,7'd38,7'd6,7'd46,7'd14,7'd54,7'd22,7'd62,7'd30,7'd37,7'd5,7'd45,7'd13,
        7'd53,7'd21,7'd61,7'd29,7'd36,7'd4,7'd44,7'd12,7'd52,7'd20,7'd60,7'd28,7'd35,7'd3,
        7'd43,7'd11,7'd51,7'd19,7'd59,7'd27,7'd34,7'd2,7'd42,7'd10,7'd50,7'd18,7'd58,7'd26,
        7'd33,7'd1,7'd41,7'd9,7'd49,7'd17,7'd57,7'd25};
    localparam logic [5:0] ETab [48] = '{
        6'd32,6'd1,6'd2,6'd3,6'd4,6'd5,6'd4,6'd5,6'd6,6'd7,6'd8,6'd9,6'd8,6'd9,6'd10,6'd11,
        6'd12,6'd13,6'd12,6'd13,6'd14,6'd15,6'd16,6'd17,6'd16,6'd17,6'd18,6'd19,6'd20,6'd21,
        6'd20,6'd21,6'd22,6'd23,6'd24,6'd25,6'd24,6'd25,6'd26,6'd27,6'd28,6'd29,6'd28,6'd29,
        6'd30,6'd31,6'd32,6'd1};
    localparam logic [5:0] PTab [32] = '{
        6'd16,6'd7,6'd20,6'd21,6'd29,6'd12,6'd28,6'd17,6'd1,6'd15,6'd23,6'd26,6'd5,6'd18,
        6'd31,6'd10,6'd2,6'd8,6'd24,6'd14,6'd32,6'd27,6'd3,6'd9,6'd19,6'd13,6'd30,6'd6,
        6'd22,6'd11,6'd4,6'd25};
    localparam logic [6:0] Pc1Tab [56] = '{
        7'd57,7'd49,7'd41,7'd33,7'd25,7'd17,7'd9,7'd1,7'd58,7'd50,7'd42,7'd34,7'd26,7'd18,
        7'd10,7'd2,7'd59,7'd51,7'd43,7'd35,7'd27,7'd19,7'd11,7'd3,7'd60,7'd52,7'd44,7'd36,
        7'd63,7'd55,7'd47,7'd39,7'd31,7'd23,7'd15,7'd7,7'd62,7'd54,7'd46,7'd38,7'd30,7'd22,
        7'd14,7'd6,7'd61,7'd53,7'd45,7'd37,7'd29,7'd21,7'd13,7'd5,7'd28,7'd20,7'd12,7'd4};
    localparam logic [5:0] Pc2Tab [48] = '{
        6'd14,6'd17,6'd11,6'd24,6'd1,6'd5,6'd3,6'd28,6'd15,6'd6,6'd21,6'd10,6'd23,6'd19,
        6'd12,6'd4,6'd26,6'd8,6'd16,6'd7,6'd27,6'd20,6'd13,6'd2,6'd41,6'd52,6'd31,6'd37,
        6'd47,6'd55,6'd30,6'd40,6'd51,6'd45,6'd33,6'd48,6'd44,6'd49,6'd39,6'd56,6'd34,6'd53,
        6'd46,6'd42,6'd50,6'd36,6'd29,6'd32};

    // Tables count bits from the MSB, starting at 1.
    function automatic logic [63:0] init_perm(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63 - i] = x[64 - int'(IpTab[i])];
        return r;
    endfunction

    function automatic logic [63:0] final_perm(input logic [63:0] x);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63 - i] = x[64 - int'(FpTab[i])];
        return r;
    endfunction

    function automatic logic [55:0] pc1(input logic [63:0] x);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55 - i] = x[64 - int'(Pc1Tab[i])];
        return r;
    endfunction

    function automatic logic [47:0] pc2(input logic [55:0] x);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47 - i] = x[56 - int'(Pc2Tab[i])];
        return r;
    endfunction

    function automatic logic [27:0] rotl28(input logic [27:0] v, input logic [4:0] s);
        return (s == 5'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    endfunction

    function automatic subkeys_t key_schedule(input logic [63:0] key);
        subkeys_t    ks;
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        cd = pc1(key);
        c  = cd[55:28];
        d  = cd[27:0];
        for (int i = 0; i < NumRounds; i++)
        begin
            c     = rotl28(c, RotTab[i]);
            d     = rotl28(d, RotTab[i]);
            ks[i] = pc2({c, d});
        end
        return ks;
    endfunction

    function automatic logic [31:0] round_f(input logic [31:0] r, input logic [47:0] k);
        logic [47:0] e;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) e[47 - i] = r[32 - int'(ETab[i])];
        e = e ^ k;
        for (int i = 0; i < 8; i++)
        begin
            six = e[47 - 6 * i -: 6];
            s[31 - 4 * i -: 4] = SboxTab[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31 - i] = s[32 - int'(PTab[i])];
        return p;
    endfunction

endpackage

FILE: sv/des_round_cell.sv
// One Feistel round cell: a pipeline stage with its round logic.
module des_round_cell
    import des_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  stage_t  stage_in,
    input  subkey_t key_enc,
    input  subkey_t key_dec,
    output stage_t  stage_out
);

    stage_t  stage_reg;
    stage_t  stage_next;
    subkey_t key_sel;

    always_comb
    begin
        key_sel            = stage_in.decrypt ? key_dec : key_enc;
        stage_next.valid   = stage_in.valid;
        stage_next.decrypt = stage_in.decrypt;
        stage_next.left    = stage_in.right;
        stage_next.right   = stage_in.left ^ round_f(stage_in.right, key_sel);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

FILE: sv/des_block_cipher.sv
// DES ECB engine top level: key register, round-cell chain, output register.
//
// Usage:
//   Key channel: cfg_valid/cfg_ready with cfg_data (64-bit key, parity bits
//   ignored). cfg_ready is always high; write only while no transaction is
//   in flight. The round keys are expanded from the key register.
//   Command channel: a transaction is accepted when start is high and busy
//   is low. busy is always low: one block is taken every cycle.
//   Result: block_out is valid for exactly one cycle while done is high.
//   The receiver cannot stall; every result must be taken when shown.
// Pipeline: input register, 16 round cells, output register between accept
//   and done. Throughput: one block per cycle, set by the 16-cell
//   chain, one Feistel round per cell.
// Reset: rst_n clears the key to zero and empties the pipeline; blocks in
//   flight are dropped.
module des_block_cipher
    import des_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [63:0] block_in,
    output logic        done,
    output logic [63:0] block_out
);

    logic [63:0] key_reg;
    stage_t      in_reg;
    stage_t      in_next;
    stage_t      chain [NumRounds + 1];
    subkeys_t    subkeys;
    logic        done_reg;
    logic [63:0] out_reg;
    logic [63:0] out_next;
    logic [63:0] ip_val;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            key_reg <= cfg_data;
        end
    end

    // Static between transactions, so the expansion is pure wiring + rotates.
    assign subkeys = key_schedule(key_reg);

    always_comb
    begin
        ip_val          = init_perm(block_in);
        in_next.valid   = start && !busy;
        in_next.decrypt = action;
        in_next.left    = ip_val[63:32];
        in_next.right   = ip_val[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg <= in_next;
        end
    end

    assign chain[0] = in_reg;

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        des_round_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (chain[g]),
            .key_enc   (subkeys[g]),
            .key_dec   (subkeys[NumRounds - 1 - g]),
            .stage_out (chain[g + 1])
        );
    end

    // Halves swap before the final permutation.
    assign out_next = final_perm({chain[NumRounds].right, chain[NumRounds].left});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[NumRounds].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign done      = done_reg;
    assign block_out = out_reg;

endmodule

FILE: sv/des_checker.sv
// Port-level checker for the DES engine, bound to the top level.
module des_checker
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic cfg_ready,
    input logic done
);

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
        else $error("cfg_ready dropped");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##18 done)
        else $error("result missing after 18 cycles");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 18))
        else $error("result without transaction");

endmodule

bind des_block_cipher des_checker u_des_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .done      (done)
);

FILE: test/testbench.sv
// Testbench for the DES ECB engine: directed vectors plus random blocks, checked by a DES model.
`timescale 1ns / 100ps

module testbench;
    import des_pkg::*;

    localparam int Latency    = 18;
    localparam int CycleLimit = 400000;

    // Encrypt/decrypt selector on the action port.
    typedef enum logic { DIR_ENC = 1'b0, DIR_DEC = 1'b1 } direction_e;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [63:0] cfg_data;
    logic        start;
    logic        busy;
    logic        action;
    logic [63:0] block_in;
    logic        done;
    logic [63:0] block_out;

    // Model copy of the key register and the queue of expected results.
    logic [63:0] model_key;
    logic [63:0] pending_blocks [$];

    int mismatch_count;
    int result_count;
    int sent_count;
    int enc_count;
    int dec_count;
    int key_writes;
    int cycle_count;

    des_block_cipher u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .block_in  (block_in),
        .done      (done),
        .block_out (block_out)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // ---- DES model, built from the standard tables ----

    // Gather bits: output bit i (from the top) is input bit tab[i], MSB numbered 1.
    function automatic logic [63:0] gather_bits(input logic [63:0] x, input int width,
                                                input int tab [], input int n);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < n; i++)
            r = {r[62:0], x[width - tab[i]]};
        return r;
    endfunction

    function automatic logic [63:0] des_transform(input logic [63:0] key,
                                                  input logic [63:0] blk,
                                                  input direction_e dir);
        int ip [] = '{58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
                      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
                      57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
                      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
        int fp [] = '{40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
                      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
                      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
                      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
        int ex [] = '{32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
                      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
                      28,29,30,31,32,1};
        int pb [] = '{16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
                      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
        int c1 [] = '{57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
                      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
                      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
                      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
        int c2 [] = '{14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8,
                      16,7,27,20,13,2, 41,52,31,37,47,55, 30,40,51,45,33,48,
                      44,49,39,56,34,53, 46,42,50,36,29,32};
        int shifts [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
        logic [47:0] subkey [16];
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        logic [63:0] x;
        logic [31:0] lh;
        logic [31:0] rh;
        logic [31:0] tmp;
        logic [47:0] e;
        logic [31:0] s;
        logic [5:0]  six;
        logic [47:0] k;
        cd = gather_bits(key, 64, c1, 56);
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++)
        begin
            for (int j = 0; j < shifts[i]; j++)
            begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            subkey[i] = gather_bits({c, d}, 56, c2, 48);
        end
        x  = gather_bits(blk, 64, ip, 64);
        lh = x[63:32];
        rh = x[31:0];
        for (int i = 0; i < 16; i++)
        begin
            k = (dir == DIR_DEC) ? subkey[15 - i] : subkey[i];
            e = gather_bits({32'h0, rh}, 32, ex, 48) ^ k;
            for (int b = 0; b < 8; b++)
            begin
                six = e[47 - 6 * b -: 6];
                // Row from the outer bits, column from the middle four.
                s[31 - 4 * b -: 4] = SboxTab[b][{six[5], six[0], six[4:1]}];
            end
            tmp = lh ^ gather_bits({32'h0, s}, 32, pb, 32);
            lh  = rh;
            rh  = tmp;
        end
        return gather_bits({rh, lh}, 64, fp, 64);
    endfunction

    // ---- Result checker: done cannot be held off, so sample every edge ----
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            result_count <= result_count + 1;
            if (pending_blocks.size() == 0)
            begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= 10)
                    $display("Unexpected result %h", block_out);
            end
            else
            begin
                if (block_out !== pending_blocks[0])
                begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("block_out mismatch: expected %h actual %h",
                                 pending_blocks[0], block_out);
                end
                void'(pending_blocks.pop_front());
            end
        end
    end

    // ---- Driving tasks ----

    // One command transaction; start stays high when the next call follows directly.
    task automatic send_block(input direction_e dir, input logic [63:0] blk);
        start    <= 1'b1;
        action   <= dir;
        block_in <= blk;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_blocks.push_back(des_transform(model_key, blk, dir));
        sent_count = sent_count + 1;
        if (dir == DIR_DEC)
            dec_count = dec_count + 1;
        else
            enc_count = enc_count + 1;
    endtask

    task automatic idle_cycles(input int n);
        start <= 1'b0;
        repeat (n)
            @(posedge clk);
    endtask

    // Drain the pipeline, then let the latency pass before touching the key.
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (pending_blocks.size() != 0)
            @(posedge clk);
        repeat (Latency + 2)
            @(posedge clk);
    endtask

    task automatic write_key(input logic [63:0] key);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= key;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        model_key = key;
        key_writes = key_writes + 1;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // ---- Tests ----

    // Extremes of the block and key, both directions, parity-only keys.
    task automatic test_directed();
        send_block(DIR_ENC, 64'h0);
        send_block(DIR_DEC, 64'h0);
        send_block(DIR_ENC, '1);
        send_block(DIR_DEC, '1);
        write_key(64'h1334_5779_9BBC_DFF1);
        send_block(DIR_ENC, 64'h0123_4567_89AB_CDEF);
        send_block(DIR_DEC, 64'h85E8_1354_0F0A_B405);
        send_block(DIR_ENC, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(DIR_ENC, 64'h5555_5555_5555_5555);
        // Parity bits alone set: must behave like the all-zero key.
        write_key(64'h0101_0101_0101_0101);
        send_block(DIR_ENC, 64'h0);
        send_block(DIR_DEC, '1);
        write_key('1);
        send_block(DIR_ENC, 64'h0);
        send_block(DIR_DEC, '1);
        send_block(DIR_ENC, 64'h8000_0000_0000_0001);
        // Key with odd parity in every byte.
        write_key(64'hFEFE_FEFE_FEFE_FEFE);
        send_block(DIR_ENC, 64'h0123_4567_89AB_CDEF);
        send_block(DIR_DEC, 64'h0123_4567_89AB_CDEF);
        idle_cycles(1);
    endtask

    // Random blocks in random directions, with random keys and gaps.
    task automatic test_random(input int count);
        logic [63:0] blk;
        direction_e  dir;
        int          burst;
        for (int n = 0; n < count; )
        begin
            if (n % 400 == 0)
                write_key(rand64());
            burst = $urandom_range(1, 40);
            for (int b = 0; b < burst && n < count; b++)
            begin
                blk = rand64();
                dir = direction_e'($urandom_range(0, 1));
                send_block(dir, blk);
                n++;
            end
            // Some bursts run without any gap at all.
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 6));
        end
        idle_cycles(1);
    endtask

    // Pause until everything is back, then one full-rate stream.
    task automatic test_full_rate();
        wait_drained();
        for (int n = 0; n < 100; n++)
            send_block(direction_e'(n[0]), rand64());
        idle_cycles(1);
    endtask

    initial
    begin
        clk_init();
    end

    task automatic clk_init();
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        start          = 1'b0;
        action         = 1'b0;
        block_in       = '0;
        model_key      = '0;
        mismatch_count = 0;
        result_count   = 0;
        sent_count     = 0;
        enc_count      = 0;
        dec_count      = 0;
        key_writes     = 0;
        cycle_count    = 0;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random(1500);
        test_full_rate();
        write_key(64'h0);
        test_random(100);

        wait_drained();
        $display("Sent %0d blocks (%0d encrypt, %0d decrypt), %0d results, %0d key writes",
                 sent_count, enc_count, dec_count, result_count, key_writes);
        if (mismatch_count == 0 && pending_blocks.size() == 0)
            $display("Verification passed");
        else
        begin
            $display("%0d mismatches, %0d results missing",
                     mismatch_count, pending_blocks.size());
            $display("Verification failed");
        end
        $finish;
    endtask

endmodule

FILE: des_block_cipher.f
sv/des_pkg.sv
sv/des_round_cell.sv
sv/des_block_cipher.sv
sv/des_checker.sv
test/testbench.sv
